// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the matrix-vector transform.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, quiet during reset
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, quiet during reset
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/m4vt_pkg.sv =====
// Shared constants for the 4x4 fixed-point matrix-vector transform.
// No dependencies.
`default_nettype none

package m4vt_pkg;

  // Fixed widths of the Q16.16 datapath
  localparam int unsigned COMP_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * COMP_W;
  localparam int unsigned NUM_COMP = 4;

  // Matrix dimension: default and upper bound
  localparam int unsigned DIM_DEF = 4;
  localparam int unsigned DIM_MAX = 4;

  // Configuration register file: two elements per register
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned REG_SEL_W = $clog2(NUM_REGS);

  // Unity in Q16.16, used for the identity matrix at reset
  localparam logic [COMP_W-1:0] Q_ONE = 32'h0001_0000;

  // Saturation limits
  localparam logic [COMP_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [COMP_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== rtl/matrix4_vector_transform.sv =====
// Top level of the fixed-point matrix-vector transform: configuration
// registers, the chain of column cells and the output stage.
// Depends on m4vt_pkg, m4vt_cell, m4vt_sat and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Multiplies each incoming vector (x, y, z, w; signed Q16.16) by a row-major
// matrix held in eight 64-bit registers, identity after reset. Register 2*R
// holds elements (R,0) in its low and (R,1) in its high half, register 2*R+1
// elements (R,2) and (R,3); writes to index 8 or above are dropped. Each
// result component is the exact dot product, shifted right 16 bits toward
// minus infinity and clamped to signed 32 bits; tuser flags any clamp.
// Throughput is one vector per clock while the output is not stalled. Each
// vector walks a chain of DIM column cells, each with DIM 32x32 multipliers,
// and then an output register that adds, shifts and saturates. Any stage that
// is empty takes a new request while a finished result waits downstream.
// Components at or beyond DIM read as zero; a DIM above four acts as four.
// Write configuration only while the block is idle.
module matrix4_vector_transform #(
  parameter int unsigned DIM = m4vt_pkg::DIM_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [m4vt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [m4vt_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  // input vectors
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
  input  logic [m4vt_pkg::NUM_COMP*m4vt_pkg::COMP_W-1:0] s_axis_tdata,
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
  output logic [m4vt_pkg::NUM_COMP*m4vt_pkg::COMP_W-1:0] m_axis_tdata,
  // saturated [0]
  output logic [0:0]                        m_axis_tuser
);
  import m4vt_pkg::*;

  // Dimension in use, limited to the size of the matrix
  localparam int unsigned DIM_N = (DIM > DIM_MAX) ? DIM_MAX : DIM;
  localparam int unsigned ACC_W = PROD_W + $clog2(DIM_N);

  logic [COMP_W-1:0]        mat_q  [DIM_MAX][DIM_MAX];
  logic                     cfg_wr;
  logic signed [COMP_W-1:0] vec_in [NUM_COMP];
  logic signed [COMP_W-1:0] col_w  [DIM_N][DIM_N];

  logic                     stg_vld [DIM_N+1];
  logic                     stg_rdy [DIM_N+1];
  logic signed [COMP_W-1:0] stg_vec [DIM_N+1][NUM_COMP];
  logic signed [ACC_W-1:0]  stg_acc [DIM_N+1][DIM_N];
  logic signed [PROD_W-1:0] stg_prd [DIM_N+1][DIM_N];

  logic [COMP_W-1:0]        res    [DIM_N];
  logic                     sat;
  logic [DIM_N-1:0]         busy;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM_MAX; r++) begin
        for (int c = 0; c < DIM_MAX; c++) begin
          mat_q[r][c] <= (r == c) ? Q_ONE : '0;
        end
      end
    end else if (cfg_wr) begin
      for (int r = 0; r < DIM_MAX; r++) begin
        for (int h = 0; h < 2; h++) begin
          if (cfg_index_i[REG_SEL_W-1:1] == (REG_SEL_W-1)'(r) &&
              cfg_index_i[0] == 1'(h)) begin
            mat_q[r][2*h]   <= cfg_data_i[COMP_W-1:0];
            mat_q[r][2*h+1] <= cfg_data_i[CFG_DAT_W-1:COMP_W];
          end
        end
      end
    end
  end

  // Unpack the request and feed the head of the chain with empty sums
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_unpack
    assign vec_in[c] = s_axis_tdata[c*COMP_W +: COMP_W];
  end

  assign stg_vld[0]   = s_axis_tvalid;
  assign s_axis_tready = stg_rdy[0];
  assign stg_vec[0]   = vec_in;
  for (genvar r = 0; r < DIM_N; r++) begin : g_head
    assign stg_acc[0][r] = '0;
    assign stg_prd[0][r] = '0;
  end

  // Chain of column cells
  for (genvar c = 0; c < DIM_N; c++) begin : g_cell
    for (genvar r = 0; r < DIM_N; r++) begin : g_col
      assign col_w[c][r] = mat_q[r][c];
    end

    m4vt_cell #(
      .DIM (DIM_N),
      .COL (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[c]),
      .ready_o (stg_rdy[c]),
      .vec_i   (stg_vec[c]),
      .elem_i  (col_w[c]),
      .acc_i   (stg_acc[c]),
      .prod_i  (stg_prd[c]),
      .valid_o (stg_vld[c+1]),
      .ready_i (stg_rdy[c+1]),
      .vec_o   (stg_vec[c+1]),
      .acc_o   (stg_acc[c+1]),
      .prod_o  (stg_prd[c+1])
    );

    assign busy[c] = stg_vld[c+1];
  end

  // Final add, saturate and hold the result
  m4vt_sat #(
    .DIM (DIM_N)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_vld[DIM_N]),
    .ready_o (stg_rdy[DIM_N]),
    .acc_i   (stg_acc[DIM_N]),
    .prod_i  (stg_prd[DIM_N]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res),
    .sat_o   (sat)
  );

  // Pack the result; components beyond the dimension stay zero
  for (genvar r = 0; r < NUM_COMP; r++) begin : g_pack
    if (r < DIM_N) begin : g_live
      assign m_axis_tdata[r*COMP_W +: COMP_W] = res[r];
    end else begin : g_zero
      assign m_axis_tdata[r*COMP_W +: COMP_W] = '0;
    end
  end
  assign m_axis_tuser = sat;

  // An empty output register lets the whole chain take a request
  `ASSERT_IMPL(a_ready_when_drained, !m_axis_tvalid, s_axis_tready,
               "input stalled although the output register is empty")
  // No result appears unless something was in flight or accepted
  `ASSERT_NEXT(a_no_phantom, !(s_axis_tvalid && s_axis_tready) && !(|busy) && !m_axis_tvalid,
               !m_axis_tvalid, "result appeared from an empty pipeline")
  // The clamp flag goes with at least one component at a limit
  `ASSERT_IMPL(a_sat_at_limit, m_axis_tvalid && m_axis_tuser[0],
               m_axis_tdata[31:0] == SAT_MAX || m_axis_tdata[31:0] == SAT_MIN ||
               m_axis_tdata[63:32] == SAT_MAX || m_axis_tdata[63:32] == SAT_MIN ||
               m_axis_tdata[95:64] == SAT_MAX || m_axis_tdata[95:64] == SAT_MIN ||
               m_axis_tdata[127:96] == SAT_MAX || m_axis_tdata[127:96] == SAT_MIN,
               "saturation flagged without a clamped component")

endmodule

`default_nettype wire

// ===== rtl/m4vt_cell.sv =====
// One column cell of the transform: multiplies one vector component by a
// matrix column and folds the previous cell's products into running sums.
// Depends on m4vt_pkg.
`default_nettype none

module m4vt_cell #(
  parameter int unsigned DIM = m4vt_pkg::DIM_DEF,
  parameter int unsigned COL = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic signed [m4vt_pkg::COMP_W-1:0]                 vec_i  [m4vt_pkg::NUM_COMP],
  input  logic signed [m4vt_pkg::COMP_W-1:0]                 elem_i [DIM],
  input  logic signed [m4vt_pkg::PROD_W+$clog2(DIM)-1:0]     acc_i  [DIM],
  input  logic signed [m4vt_pkg::PROD_W-1:0]                 prod_i [DIM],
  output logic valid_o,
  input  logic ready_i,
  output logic signed [m4vt_pkg::COMP_W-1:0]                 vec_o  [m4vt_pkg::NUM_COMP],
  output logic signed [m4vt_pkg::PROD_W+$clog2(DIM)-1:0]     acc_o  [DIM],
  output logic signed [m4vt_pkg::PROD_W-1:0]                 prod_o [DIM]
);
  import m4vt_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(DIM);

  logic                      valid_q;
  logic signed [COMP_W-1:0]  vec_q  [NUM_COMP];
  logic signed [ACC_W-1:0]   acc_d  [DIM];
  logic signed [ACC_W-1:0]   acc_q  [DIM];
  logic signed [PROD_W-1:0]  prod_d [DIM];
  logic signed [PROD_W-1:0]  prod_q [DIM];
  logic                      load;

  // Take a request when empty or when the neighbour drains this stage
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Fold the upstream product into the sum; form this column's products
  for (genvar r = 0; r < DIM; r++) begin : g_row
    assign acc_d[r]  = acc_i[r] + {{(ACC_W-PROD_W){prod_i[r][PROD_W-1]}}, prod_i[r]};
    assign prod_d[r] = elem_i[r] * vec_i[COL];
  end

  // Occupancy of this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload: partial sums, fresh products and the vector for later cells
  always_ff @(posedge clk_i) begin
    if (load) begin
      vec_q  <= vec_i;
      acc_q  <= acc_d;
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign acc_o   = acc_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

// ===== rtl/m4vt_sat.sv =====
// Output stage of the transform: final add, shift by the fraction width,
// saturation to 32 bits and the registered result. Depends on m4vt_pkg.
`default_nettype none

module m4vt_sat #(
  parameter int unsigned DIM = m4vt_pkg::DIM_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic signed [m4vt_pkg::PROD_W+$clog2(DIM)-1:0] acc_i  [DIM],
  input  logic signed [m4vt_pkg::PROD_W-1:0]             prod_i [DIM],
  output logic valid_o,
  input  logic ready_i,
  output logic [m4vt_pkg::COMP_W-1:0]                    res_o  [DIM],
  output logic                                           sat_o
);
  import m4vt_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(DIM);
  localparam int unsigned SH_W  = ACC_W - FRAC_W;
  localparam int unsigned TOP_W = SH_W - COMP_W + 1;

  logic                     valid_q;
  logic signed [ACC_W-1:0]  sum    [DIM];
  logic        [SH_W-1:0]   shr    [DIM];
  logic        [TOP_W-1:0]  upper  [DIM];
  logic        [DIM-1:0]    ovf;
  logic        [COMP_W-1:0] res_d  [DIM];
  logic        [COMP_W-1:0] res_q  [DIM];
  logic                     sat_q;

  assign ready_o = !valid_q || ready_i;

  // Add the last product, drop the fraction (floor), clamp to 32 bits
  for (genvar r = 0; r < DIM; r++) begin : g_row
    assign sum[r]   = acc_i[r] + {{(ACC_W-PROD_W){prod_i[r][PROD_W-1]}}, prod_i[r]};
    assign shr[r]   = sum[r][ACC_W-1:FRAC_W];
    assign upper[r] = shr[r][SH_W-1:COMP_W-1];
    assign ovf[r]   = !((&upper[r]) || !(|upper[r]));
    assign res_d[r] = !ovf[r]           ? shr[r][COMP_W-1:0] :
                      shr[r][SH_W-1]    ? SAT_MIN : SAT_MAX;
  end

  // Occupancy of the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
      sat_q <= |ovf;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire
